// ===== rtl/tmlt_pkg.sv =====
// shared types, codes and sizes for the typed mutex lock table
// used by tmlt_store, tmlt_eval and typed_mutex_lock_table
package tmlt_pkg;

    localparam int NUM_LOCKS = 64;
    localparam int MAX_DEPTH = 255;
    localparam int IDX_W     = 6;
    localparam int DEPTH_CAP = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_DESTROY = 3'd1;
    localparam logic [2:0] CMD_LOCK    = 3'd2;
    localparam logic [2:0] CMD_TRYLOCK = 3'd3;
    localparam logic [2:0] CMD_UNLOCK  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_DEADLOCK = 3'd3;
    localparam logic [2:0] ST_NOTOWNER = 3'd4;
    localparam logic [2:0] ST_RETRY    = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [1:0] TY_NORMAL    = 2'd0;
    localparam logic [1:0] TY_RECURSIVE = 2'd1;
    localparam logic [1:0] TY_ERRCHECK  = 2'd2;
    localparam logic [1:0] TY_REJECTED  = 2'd3;

    typedef struct packed {
        logic       held;
        logic [1:0] ltype;
        logic [7:0] owner;
        logic [7:0] depth;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{held: 1'b0, ltype: TY_NORMAL, owner: 8'd0, depth: 8'd0};

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr;

    typedef struct packed {
        logic [2:0]       command;
        logic [IDX_W-1:0] lock_index;
        logic [7:0]       requester;
        logic [1:0]       lock_type;
    } t_item;

    typedef struct packed {
        logic acquire;
        logic release_;
        logic contention;
    } t_count_inc;

endpackage

// ===== rtl/tmlt_store.sv =====
// lock entry store: one-read one-write memory with per-entry valid bits
// and write-to-read bypass; depends on tmlt_pkg
module tmlt_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [tmlt_pkg::IDX_W-1:0] i_rd_addr,
    input  tmlt_pkg::t_wr             i_wr,
    output tmlt_pkg::t_entry          o_rd_data
);

    tmlt_pkg::t_entry                    mem [tmlt_pkg::NUM_LOCKS];
    logic [tmlt_pkg::NUM_LOCKS-1:0]      r_valid;
    tmlt_pkg::t_entry                    r_rd_data;
    logic                                r_rd_valid;
    logic                                r_byp;
    tmlt_pkg::t_entry                    r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_byp_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_byp      <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp      ? r_byp_data :
                       r_rd_valid ? r_rd_data  : tmlt_pkg::ENTRY_RESET;

endmodule

// ===== rtl/tmlt_eval.sv =====
// per-request decision logic: new entry, status and counter bumps
// depends on tmlt_pkg
module tmlt_eval (
    input  tmlt_pkg::t_item       i_item,
    input  tmlt_pkg::t_entry      i_entry,
    output tmlt_pkg::t_entry      o_entry,
    output logic [2:0]            o_status,
    output tmlt_pkg::t_count_inc  o_inc
);

    logic             invalid;
    logic             mine;
    logic             at_cap;
    tmlt_pkg::t_entry taken;
    tmlt_pkg::t_entry freed;

    always_comb begin
        invalid = (i_item.requester == 8'd0) || (i_item.command > tmlt_pkg::CMD_UNLOCK)
                  || ({1'b0, i_item.lock_index} >= (tmlt_pkg::IDX_W+1)'(tmlt_pkg::NUM_LOCKS));
        mine    = i_entry.held && (i_entry.owner == i_item.requester);
        at_cap  = i_entry.depth >= 8'(tmlt_pkg::DEPTH_CAP);

        taken       = i_entry;
        taken.held  = 1'b1;
        taken.owner = i_item.requester;
        taken.depth = 8'd1;

        freed       = i_entry;
        freed.held  = 1'b0;
        freed.owner = 8'd0;
        freed.depth = 8'd0;

        o_entry  = i_entry;
        o_status = tmlt_pkg::ST_OK;
        o_inc    = '0;

        if (invalid) begin
            o_status = tmlt_pkg::ST_INVALID;
        end else begin
            case (i_item.command)
                tmlt_pkg::CMD_INIT: begin
                    if (i_item.lock_type == tmlt_pkg::TY_REJECTED) begin
                        o_status = tmlt_pkg::ST_INVALID;
                    end else begin
                        o_entry       = freed;
                        o_entry.ltype = i_item.lock_type;
                    end
                end
                tmlt_pkg::CMD_DESTROY: begin
                    o_status = i_entry.held ? tmlt_pkg::ST_BUSY : tmlt_pkg::ST_OK;
                end
                tmlt_pkg::CMD_LOCK, tmlt_pkg::CMD_TRYLOCK: begin
                    if (mine && i_entry.ltype == tmlt_pkg::TY_RECURSIVE) begin
                        if (at_cap) begin
                            o_status = tmlt_pkg::ST_OVERFLOW;
                        end else begin
                            o_entry.depth = i_entry.depth + 8'd1;
                        end
                    end else if (i_item.command == tmlt_pkg::CMD_TRYLOCK) begin
                        if (i_entry.held) begin
                            o_status = tmlt_pkg::ST_BUSY;
                        end else begin
                            o_entry       = taken;
                            o_inc.acquire = 1'b1;
                        end
                    end else if (mine && i_entry.ltype == tmlt_pkg::TY_ERRCHECK) begin
                        o_status = tmlt_pkg::ST_DEADLOCK;
                    end else if (i_entry.held) begin
                        o_status         = tmlt_pkg::ST_RETRY;
                        o_inc.contention = 1'b1;
                    end else begin
                        o_entry       = taken;
                        o_inc.acquire = 1'b1;
                    end
                end
                tmlt_pkg::CMD_UNLOCK: begin
                    if (!mine) begin
                        o_status = tmlt_pkg::ST_NOTOWNER;
                    end else if (i_entry.ltype == tmlt_pkg::TY_RECURSIVE
                                 && i_entry.depth > 8'd1) begin
                        o_entry.depth = i_entry.depth - 8'd1;
                    end else begin
                        o_entry        = freed;
                        o_inc.release_ = 1'b1;
                    end
                end
                default: begin
                    o_status = tmlt_pkg::ST_INVALID;
                end
            endcase
        end
    end

endmodule

// ===== rtl/typed_mutex_lock_table.sv =====
// top level of the typed mutex lock table: handshake, request and result
// registers, global totals; depends on tmlt_pkg, tmlt_store, tmlt_eval
//
// usage
//   requests enter on the s_axis channel, one beat per request; results
//   leave on the m_axis channel, one beat per request, in request order
//   a beat is taken at a rising edge with tvalid and tready both high
//   a request beat waits in the request register while the store reads
//   its lock, then its result goes to the output register; one request
//   per cycle is sustained while m_axis_tready is high, the registered read
//   feeding decision logic, bypassed if the previous request wrote the same lock
//   reset (i_rst_n low, synchronous) frees all locks, sets every type to
//   normal and zeroes the totals at once through per-lock valid bits
//   when the receiver holds m_axis_tready low the result stays in place,
//   one more request is held in the request register and s_axis_tready
//   then drops until the result beat is taken
module typed_mutex_lock_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], lock_index[8:3], requester[16:9], lock_type[18:17], zero fill
    input  logic [23:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], owner_id[10:3], hold_depth[18:11], is_held[19],
    // total_acquires[51:20], total_releases[83:52], contend_total[115:84],
    // zero fill
    output logic [119:0] m_axis_tdata
);

    tmlt_pkg::t_item      in_item;
    tmlt_pkg::t_item      r_item;
    logic                 r_item_vld;
    logic                 r_out_vld;
    logic [119:0]         r_out;
    logic [31:0]          r_acq;
    logic [31:0]          r_rel;
    logic [31:0]          r_cont;
    logic [31:0]          n_acq;
    logic [31:0]          n_rel;
    logic [31:0]          n_cont;
    logic                 proc;
    logic                 acc;
    tmlt_pkg::t_entry     cur_entry;
    tmlt_pkg::t_entry     new_entry;
    logic [2:0]           status;
    tmlt_pkg::t_count_inc inc;
    tmlt_pkg::t_wr        wr;

    assign in_item.command    = s_axis_tdata[2:0];
    assign in_item.lock_index = s_axis_tdata[8:3];
    assign in_item.requester  = s_axis_tdata[16:9];
    assign in_item.lock_type  = s_axis_tdata[18:17];

    assign proc          = r_item_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_item_vld || proc;
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign wr.en   = proc;
    assign wr.addr = r_item.lock_index;
    assign wr.data = new_entry;

    tmlt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (in_item.lock_index),
        .i_wr      (wr),
        .o_rd_data (cur_entry)
    );

    tmlt_eval u_eval (
        .i_item   (r_item),
        .i_entry  (cur_entry),
        .o_entry  (new_entry),
        .o_status (status),
        .o_inc    (inc)
    );

    assign n_acq  = r_acq  + 32'(inc.acquire);
    assign n_rel  = r_rel  + 32'(inc.release_);
    assign n_cont = r_cont + 32'(inc.contention);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_acq      <= '0;
            r_rel      <= '0;
            r_cont     <= '0;
        end else begin
            if (acc) begin
                r_item_vld <= 1'b1;
            end else if (proc) begin
                r_item_vld <= 1'b0;
            end
            if (proc) begin
                r_out_vld <= 1'b1;
                r_acq     <= n_acq;
                r_rel     <= n_rel;
                r_cont    <= n_cont;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= in_item;
        end
        if (proc) begin
            r_out <= {4'd0, n_cont, n_rel, n_acq, new_entry.held,
                      new_entry.depth, new_entry.owner, status};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

// ===== sim/tb_top.sv =====
// self-checking bench for typed_mutex_lock_table: directed, depth-saturation,
// backpressure and random traffic checked beat by beat against a local lock model
// depends on tmlt_pkg and the typed_mutex_lock_table rtl
`timescale 1ns / 100ps

module tb_top;
    import tmlt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  owner_id;
        logic [7:0]  hold_depth;
        logic        is_held;
        logic [31:0] total_acquires;
        logic [31:0] total_releases;
        logic [31:0] contend_total;
    } t_lock_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // command, lock_index, requester, lock_type, zero fill
    logic [23:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, owner_id, hold_depth, is_held, total_acquires, total_releases,
    // contend_total, zero fill
    logic [119:0] m_axis_tdata;

    // lock bank as the block should see it
    logic        lk_held  [NUM_LOCKS];
    logic [1:0]  lk_type  [NUM_LOCKS];
    logic [7:0]  lk_owner [NUM_LOCKS];
    logic [7:0]  lk_depth [NUM_LOCKS];
    logic [31:0] acquire_count;
    logic [31:0] release_count;
    logic [31:0] contend_tally;

    t_lock_reply pending_replies[$];
    int          items_sent = 0;
    int          replies_seen = 0;
    int          fail_count = 0;
    int          status_seen[8];
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    int          hold_req = 0;
    int          rx_stall_left = 0;

    typed_mutex_lock_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [2:0] deepen(int i);
        if (lk_depth[i] >= DEPTH_CAP)
            return ST_OVERFLOW;
        lk_depth[i] = lk_depth[i] + 8'd1;
        return ST_OK;
    endfunction

    function automatic void grab(int i, logic [7:0] who);
        lk_held[i]    = 1'b1;
        lk_owner[i]   = who;
        lk_depth[i]   = 8'd1;
        acquire_count = acquire_count + 32'd1;
    endfunction

    function automatic t_lock_reply apply_request(t_item r);
        t_lock_reply res;
        logic [2:0]  st;
        logic        mine;
        int          i;
        i = r.lock_index;
        st = ST_OK;
        mine = lk_held[i] && (lk_owner[i] == r.requester);
        if (r.requester == 8'd0 || r.command > CMD_UNLOCK) begin
            st = ST_INVALID;
        end else begin
            case (r.command)
                CMD_INIT: begin
                    if (r.lock_type == TY_REJECTED) begin
                        st = ST_INVALID;
                    end else begin
                        lk_type[i]  = r.lock_type;
                        lk_held[i]  = 1'b0;
                        lk_owner[i] = 8'd0;
                        lk_depth[i] = 8'd0;
                    end
                end
                CMD_DESTROY: st = lk_held[i] ? ST_BUSY : ST_OK;
                CMD_LOCK: begin
                    if (mine && lk_type[i] == TY_RECURSIVE) begin
                        st = deepen(i);
                    end else if (mine && lk_type[i] == TY_ERRCHECK) begin
                        st = ST_DEADLOCK;
                    end else if (lk_held[i]) begin
                        contend_tally = contend_tally + 32'd1;
                        st = ST_RETRY;
                    end else begin
                        grab(i, r.requester);
                    end
                end
                CMD_TRYLOCK: begin
                    if (mine && lk_type[i] == TY_RECURSIVE)
                        st = deepen(i);
                    else if (lk_held[i])
                        st = ST_BUSY;
                    else
                        grab(i, r.requester);
                end
                default: begin
                    if (!mine) begin
                        st = ST_NOTOWNER;
                    end else if (lk_type[i] == TY_RECURSIVE && lk_depth[i] > 8'd1) begin
                        lk_depth[i] = lk_depth[i] - 8'd1;
                    end else begin
                        lk_held[i]    = 1'b0;
                        lk_owner[i]   = 8'd0;
                        lk_depth[i]   = 8'd0;
                        release_count = release_count + 32'd1;
                    end
                end
            endcase
        end
        res.status         = st;
        res.owner_id       = lk_owner[i];
        res.hold_depth     = lk_depth[i];
        res.is_held        = lk_held[i];
        res.total_acquires = acquire_count;
        res.total_releases = release_count;
        res.contend_total  = contend_tally;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endfunction

    // receiver: random stalls plus a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            rx_stall_left = hold_req;
            hold_req = 0;
        end
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_gaps && $urandom_range(0, 99) < 20)
                rx_stall_left = pick_gap();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lock_reply want;
        t_lock_reply got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tdata[2:0];
            got.owner_id       = m_axis_tdata[10:3];
            got.hold_depth     = m_axis_tdata[18:11];
            got.is_held        = m_axis_tdata[19];
            got.total_acquires = m_axis_tdata[51:20];
            got.total_releases = m_axis_tdata[83:52];
            got.contend_total  = m_axis_tdata[115:84];
            replies_seen++;
            if (pending_replies.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $realtime, m_axis_tdata);
            end else begin
                want = pending_replies.pop_front();
                status_seen[got.status]++;
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("owner_id", 32'(want.owner_id), 32'(got.owner_id));
                check_field("hold_depth", 32'(want.hold_depth), 32'(got.hold_depth));
                check_field("is_held", 32'(want.is_held), 32'(got.is_held));
                check_field("total_acquires", want.total_acquires, got.total_acquires);
                check_field("total_releases", want.total_releases, got.total_releases);
                check_field("contend_total", want.contend_total, got.contend_total);
            end
        end
    end

    task automatic send_beat(t_item it);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {5'd0, it.lock_type, it.requester, it.lock_index, it.command};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(apply_request(it));
        items_sent++;
    endtask

    task automatic send_req(logic [2:0] cmd, logic [5:0] idx, logic [7:0] who,
                            logic [1:0] ty);
        t_item it;
        it.command    = cmd;
        it.lock_index = idx;
        it.requester  = who;
        it.lock_type  = ty;
        send_beat(it);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_reset();
        for (int i = 0; i < NUM_LOCKS; i++) begin
            lk_held[i]  = 1'b0;
            lk_type[i]  = TY_NORMAL;
            lk_owner[i] = 8'd0;
            lk_depth[i] = 8'd0;
        end
        acquire_count = '0;
        release_count = '0;
        contend_tally = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed();
        send_req(CMD_INIT, 6'd0, 8'd255, TY_NORMAL);
        send_req(CMD_LOCK, 6'd0, 8'd255, TY_NORMAL);
        send_req(CMD_LOCK, 6'd0, 8'd255, TY_NORMAL);
        send_req(CMD_TRYLOCK, 6'd0, 8'd255, TY_NORMAL);
        send_req(CMD_LOCK, 6'd0, 8'd1, TY_NORMAL);
        send_req(CMD_TRYLOCK, 6'd0, 8'd1, TY_NORMAL);
        send_req(CMD_UNLOCK, 6'd0, 8'd1, TY_NORMAL);
        send_req(CMD_DESTROY, 6'd0, 8'd1, TY_NORMAL);
        for (int c = CMD_UNLOCK + 1; c < 8; c++)
            send_req(c[2:0], 6'd0, 8'd255, TY_REJECTED);
        send_req(CMD_UNLOCK, 6'd0, 8'd0, TY_NORMAL);
        // reinit while held
        send_req(CMD_INIT, 6'd0, 8'd1, TY_ERRCHECK);
        send_req(CMD_DESTROY, 6'd0, 8'd1, TY_NORMAL);
        send_req(CMD_UNLOCK, 6'd0, 8'd1, TY_NORMAL);
        send_req(CMD_LOCK, 6'd0, 8'd2, TY_NORMAL);
        send_req(CMD_LOCK, 6'd0, 8'd2, TY_NORMAL);
        send_req(CMD_TRYLOCK, 6'd0, 8'd2, TY_NORMAL);
        send_req(CMD_UNLOCK, 6'd0, 8'd2, TY_NORMAL);
        send_req(CMD_INIT, 6'd63, 8'd128, TY_RECURSIVE);
        send_req(CMD_TRYLOCK, 6'd63, 8'd128, TY_NORMAL);
        send_req(CMD_LOCK, 6'd63, 8'd128, TY_NORMAL);
        send_req(CMD_TRYLOCK, 6'd63, 8'd128, TY_NORMAL);
        repeat (3) send_req(CMD_UNLOCK, 6'd63, 8'd128, TY_NORMAL);
        send_req(CMD_INIT, 6'd63, 8'd5, TY_REJECTED);
        send_req(CMD_LOCK, 6'd63, 8'd0, TY_RECURSIVE);
        wait_drain();
    endtask

    task automatic test_depth_saturation();
        logic [5:0] idx;
        logic [7:0] who;
        idx = 6'($urandom_range(0, 63));
        who = 8'($urandom_range(1, 255));
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_req(CMD_INIT, idx, who, TY_RECURSIVE);
        for (int n = 0; n < DEPTH_CAP + 2; n++)
            send_req(($urandom_range(0, 1) != 0) ? CMD_LOCK : CMD_TRYLOCK, idx, who,
                     2'($urandom_range(0, 3)));
        for (int n = 0; n < 3; n++)
            send_req(CMD_UNLOCK, idx, who, TY_NORMAL);
        // reinit frees the deep lock in one step
        send_req(CMD_INIT, idx, who, TY_NORMAL);
        wait_drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        logic [5:0] idx;
        idx = 6'($urandom_range(0, 63));
        tx_gaps = 1'b0;
        @(posedge i_clk);
        hold_req = 40;
        for (int n = 0; n < 16; n++)
            send_req(3'($urandom_range(CMD_DESTROY, CMD_UNLOCK)), idx,
                     8'($urandom_range(1, 3)), TY_NORMAL);
        wait_drain();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(int n_items, bit with_gaps);
        logic [5:0] locks [4];
        logic [7:0] users [3];
        logic [5:0] idx;
        logic [7:0] who;
        logic [7:0] rival;
        int         stop_at;
        int         depth_n;
        tx_gaps = with_gaps;
        rx_gaps = with_gaps;
        stop_at = items_sent + n_items;
        foreach (locks[i]) locks[i] = 6'($urandom_range(0, 63));
        foreach (users[i]) users[i] = 8'($urandom_range(1, 255));
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0)
                locks[$urandom_range(0, 3)] = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 19) == 0)
                users[$urandom_range(0, 2)] = 8'($urandom_range(1, 255));
            idx   = locks[$urandom_range(0, 3)];
            who   = users[$urandom_range(0, 2)];
            rival = users[$urandom_range(0, 2)];
            case ($urandom_range(0, 11))
                0, 1: send_req(CMD_INIT, idx, who, 2'($urandom_range(0, 3)));
                2, 3, 4, 5: begin
                    depth_n = $urandom_range(0, 3);
                    send_req(($urandom_range(0, 1) != 0) ? CMD_LOCK : CMD_TRYLOCK,
                             idx, who, 2'($urandom_range(0, 3)));
                    for (int k = 0; k < depth_n; k++)
                        send_req(($urandom_range(0, 1) != 0) ? CMD_LOCK : CMD_TRYLOCK,
                                 idx, who, 2'($urandom_range(0, 3)));
                    if ($urandom_range(0, 1) != 0)
                        send_req(($urandom_range(0, 1) != 0) ? CMD_LOCK : CMD_TRYLOCK,
                                 idx, rival, 2'($urandom_range(0, 3)));
                    for (int k = 0; k < depth_n + $urandom_range(0, 2); k++)
                        send_req(CMD_UNLOCK, idx, who, 2'($urandom_range(0, 3)));
                end
                6, 7: send_req(($urandom_range(0, 1) != 0) ? CMD_LOCK : CMD_TRYLOCK,
                               idx, rival, 2'($urandom_range(0, 3)));
                8: send_req(CMD_DESTROY, idx, who, 2'($urandom_range(0, 3)));
                9: send_req(CMD_UNLOCK, idx, rival, 2'($urandom_range(0, 3)));
                default: send_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                                  ($urandom_range(0, 5) == 0) ? 8'd0
                                                              : 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)));
            endcase
        end
        wait_drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial begin
        apply_reset();
        test_directed();
        test_depth_saturation();
        test_backpressure();
        test_random_traffic(110, 1'b1);
        test_random_traffic(40, 1'b0);
        wait_drain();
        $display("ran %0d requests, %0d results: directed, saturation, backpressure, random",
                 items_sent, replies_seen);
        $write("status counts ok %0d invalid %0d busy %0d deadlock %0d",
               status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_BUSY],
               status_seen[ST_DEADLOCK]);
        $display(" not owner %0d retry %0d overflow %0d",
                 status_seen[ST_NOTOWNER], status_seen[ST_RETRY], status_seen[ST_OVERFLOW]);
        if (fail_count == 0)
            $display("** typed_mutex_lock_table: PASSED **");
        else
            $display("** typed_mutex_lock_table: FAILED **");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pending_replies.size());
        $display("** typed_mutex_lock_table: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tmlt_pkg.sv
rtl/tmlt_store.sv
rtl/tmlt_eval.sv
rtl/typed_mutex_lock_table.sv
sim/tb_top.sv
